// ===== rtl/atp_pkg.sv =====
// Shared constants, lane types and the arctangent table for the tilt unit.
// No dependencies; every other file in rtl/ imports this package.
package atp_pkg;

  localparam int ITERATIONS    = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_STAGES = (ITERATIONS < ATAN_LEN) ? ITERATIONS : ATAN_LEN;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;            // one square, at most 2^30
  localparam int SUM_W    = 32;            // sum of two squares
  localparam int ROOT_W   = 30;            // floor(sqrt(sum * 2^28))
  localparam int REM_W    = 32;
  localparam int SQRT_STAGES = ROOT_W;     // one root bit per cell

  localparam int NUM_FRAC = 14;            // numerator scaled to match the Q14 root
  localparam int CX_W     = 34;
  localparam int ANG_W    = 25;            // Q16 degrees
  localparam int IDX_W    = 5;
  localparam int ANGLE_W  = 15;            // Q7 degrees at the output
  localparam int ANG_SHIFT = 9;            // Q16 -> Q7

  localparam logic signed [ANG_W-1:0]   DEG90_Q16  = 25'sd5898240;
  localparam logic signed [ANGLE_W-1:0] DEG90_Q7   = 15'sd11520;
  localparam logic [ANG_W-1:0]          ROUND_HALF = 25'd256;

  localparam int DUTY_W     = 13;
  localparam int DUTY_A_W   = 10;          // magnitudes below the divisor
  localparam int DUTY_FRAC  = 12;
  localparam int DUTY_NUM_W = DUTY_A_W + DUTY_FRAC;
  localparam int DUTY_K_W   = 23;
  localparam int PROD_W     = DUTY_NUM_W + DUTY_K_W;
  localparam int RECIP_SHIFT = 32;
  localparam logic [SAMPLE_W-1:0]  DUTY_DIV   = 16'd1020;
  localparam logic [DUTY_FRAC-1:0] DUTY_HALF  = 12'd510;
  // ceil(2^32 / 1020); the excess stays below 1/1020 for every numerator, so no fixup
  localparam logic [DUTY_K_W-1:0]  DUTY_RECIP = 23'd4210753;
  localparam logic [DUTY_W-1:0]    DUTY_FULL  = 13'd4096;

  // the duties reach the side line three stages in; the angle chains end later
  localparam int SIDE_DEPTH = SQRT_STAGES + CORDIC_STAGES - 1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic                       vld;
    logic [SUM_W-1:0]           rad;
    logic [REM_W-1:0]           rem;
    logic [ROOT_W-1:0]          root;
    logic signed [SAMPLE_W-1:0] num;
  } sq_lane_t;

  typedef struct packed {
    logic                    vld;
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic signed [ANG_W-1:0] ang;
    logic                    neg;
    logic                    nzero;
    logic                    mzero;
  } cr_lane_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_x;
    logic [DUTY_W-1:0] duty_y;
    logic [DUTY_W-1:0] duty_z;
    logic              upd;
  } side_t;

  // round(atan(2^-i) * 180/pi * 2^16)
  function automatic logic [ANG_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
    logic [ANG_W-1:0] v;
    begin
      case (i)
        5'd0:    v = 25'd2949120;
        5'd1:    v = 25'd1740967;
        5'd2:    v = 25'd919879;
        5'd3:    v = 25'd466945;
        5'd4:    v = 25'd234379;
        5'd5:    v = 25'd117304;
        5'd6:    v = 25'd58666;
        5'd7:    v = 25'd29335;
        5'd8:    v = 25'd14668;
        5'd9:    v = 25'd7334;
        5'd10:   v = 25'd3667;
        5'd11:   v = 25'd1833;
        5'd12:   v = 25'd917;
        5'd13:   v = 25'd458;
        5'd14:   v = 25'd229;
        5'd15:   v = 25'd115;
        5'd16:   v = 25'd57;
        5'd17:   v = 25'd29;
        5'd18:   v = 25'd14;
        5'd19:   v = 25'd7;
        5'd20:   v = 25'd4;
        5'd21:   v = 25'd2;
        5'd22:   v = 25'd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/atp_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per stage.
// Depends on atp_pkg for the lane type and widths.
module atp_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  atp_pkg::sq_lane_t lane_in,
  output atp_pkg::sq_lane_t lane_out
);
  import atp_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  // bring down the next two radicand bits and try root*4+1
  assign rem_sh = {lane_in.rem, lane_in.rad[SUM_W-1 -: 2]};
  assign trial  = {{(REM_W-ROOT_W){1'b0}}, lane_in.root, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else if (en) begin
      lane_out.vld <= lane_in.vld;
    end
    if (en) begin
      lane_out.rad  <= {lane_in.rad[SUM_W-3:0], 2'b00};
      lane_out.rem  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      lane_out.root <= {lane_in.root[ROOT_W-2:0], fits};
      lane_out.num  <= lane_in.num;
    end
  end

endmodule

// ===== rtl/atp_cordic_cell.sv =====
// One vectoring CORDIC rotation per stage; idx is tied to the cell's place in the row.
// Depends on atp_pkg for the lane type and the arctangent table.
module atp_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [atp_pkg::IDX_W-1:0]   idx,
  input  atp_pkg::cr_lane_t           lane_in,
  output atp_pkg::cr_lane_t           lane_out
);
  import atp_pkg::*;

  logic signed [CX_W-1:0]  cx_in;
  logic signed [CX_W-1:0]  cy_in;
  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [ANG_W-1:0] tab;
  logic                    up;

  assign cx_in = lane_in.cx;
  assign cy_in = lane_in.cy;
  assign xs    = cx_in >>> idx;
  assign ys    = cy_in >>> idx;
  assign tab   = $signed(atan_q16(idx));
  assign up    = !cy_in[CX_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.vld <= 1'b0;
    end else if (en) begin
      lane_out.vld <= lane_in.vld;
    end
    if (en) begin
      lane_out.cx    <= up ? cx_in + ys : cx_in - ys;
      lane_out.cy    <= up ? cy_in - xs : cy_in + xs;
      lane_out.ang   <= up ? lane_in.ang + tab : lane_in.ang - tab;
      lane_out.neg   <= lane_in.neg;
      lane_out.nzero <= lane_in.nzero;
      lane_out.mzero <= lane_in.mzero;
    end
  end

endmodule

// ===== rtl/atp_duty.sv =====
// LED duty for one axis: |v| * 4096 / 1020 rounded, saturated at 4096, three stages.
// Depends on atp_pkg for the reciprocal and widths.
module atp_duty (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [atp_pkg::SAMPLE_W-1:0] sample,
  output logic [atp_pkg::DUTY_W-1:0]          duty
);
  import atp_pkg::*;

  logic [SAMPLE_W-1:0]   mag_c;
  logic                  sat_c;
  logic [DUTY_A_W-1:0]   mag_a;
  logic                  sat_a;
  logic [DUTY_NUM_W-1:0] num;
  logic [PROD_W-1:0]     prod_c;
  logic [PROD_W-1:0]     prod;
  logic                  sat_b;

  assign mag_c  = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign sat_c  = (mag_c >= DUTY_DIV);
  assign num    = {mag_a, DUTY_HALF};
  assign prod_c = num * DUTY_RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= mag_c[DUTY_A_W-1:0];
      sat_a <= sat_c;
      prod  <= prod_c;
      sat_b <= sat_a;
      duty  <= sat_b ? DUTY_FULL : {1'b0, prod[RECIP_SHIFT+DUTY_W-2:RECIP_SHIFT]};
    end
  end

endmodule

// ===== rtl/accel_tilt_pitch_roll_unit.sv =====
// Accelerometer tilt unit: one (x, y, z) beat in, one pitch/roll/duty beat out.
// A fully pipelined design that takes a new sample every cycle while the output beat
// is not waiting; a sample passes the square and sum stages, the 30-cell square-root
// rows, the CORDIC input register, the CORDIC rows and the output register.
// The whole pipe holds while the output beat waits: s_tready = !m_tvalid || m_tready.
// Pitch and roll are signed Q7 degrees; duties are Q12; m_tuser flags z != 0.
// Depends on atp_pkg, atp_sqrt_cell, atp_cordic_cell and atp_duty.
module accel_tilt_pitch_roll_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [atp_pkg::IN_TDATA_W-1:0]     s_tdata,  // accel_x, accel_y, accel_z
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pitch_deg, roll_deg, duty_x, duty_y, duty_z, zero fill
  output logic [atp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tuser   // leds_update
);
  import atp_pkg::*;

  logic en;

  logic signed [SAMPLE_W-1:0]   in_x, in_y, in_z;
  logic signed [2*SAMPLE_W-1:0] px, py, pz;

  logic                       v1;
  logic signed [SAMPLE_W-1:0] x1, y1, z1;
  logic [SQ_W-1:0]            sqx1, sqy1, sqz1;
  logic                       upd1;

  sq_lane_t sq_p [SQRT_STAGES+1];
  sq_lane_t sq_r [SQRT_STAGES+1];
  cr_lane_t cr_p [CORDIC_STAGES+1];
  cr_lane_t cr_r [CORDIC_STAGES+1];
  cr_lane_t cr_p_in;
  cr_lane_t cr_r_in;

  logic [DUTY_W-1:0] dx, dy, dz;
  logic              upd_d [3];
  side_t             side  [SIDE_DEPTH];

  logic               out_vld;
  logic [ANGLE_W-1:0] out_pitch, out_roll;
  side_t              out_side;

  function automatic cr_lane_t prep(input sq_lane_t s);
    cr_lane_t                 c;
    logic signed [SAMPLE_W:0] nx;
    logic [SAMPLE_W:0]        an;
    begin
      nx      = {s.num[SAMPLE_W-1], s.num};
      an      = nx[SAMPLE_W] ? (SAMPLE_W+1)'(-nx) : (SAMPLE_W+1)'(nx);
      c.vld   = s.vld;
      c.cx    = {{(CX_W-ROOT_W){1'b0}}, s.root};
      c.cy    = {{(CX_W-SAMPLE_W-1-NUM_FRAC){1'b0}}, an, {NUM_FRAC{1'b0}}};
      c.ang   = '0;
      c.neg   = s.num[SAMPLE_W-1];
      c.nzero = (s.num == '0);
      c.mzero = (s.root == '0);
      return c;
    end
  endfunction

  // clamp to [0, 90], round to Q7, restore the sign; zero numerator or magnitude is special
  function automatic logic [ANGLE_W-1:0] finish_angle(input cr_lane_t c);
    logic [ANG_W-1:0]   a;
    logic [ANG_W-1:0]   r;
    logic [ANGLE_W-1:0] mag;
    logic [ANGLE_W-1:0] res;
    begin
      if (c.ang < 0) begin
        a = '0;
      end else if (c.ang > DEG90_Q16) begin
        a = DEG90_Q16;
      end else begin
        a = c.ang;
      end
      r   = a + ROUND_HALF;
      mag = {1'b0, r[ANG_SHIFT+ANGLE_W-2:ANG_SHIFT]};
      if (c.nzero) begin
        res = '0;
      end else if (c.mzero) begin
        res = c.neg ? -DEG90_Q7 : DEG90_Q7;
      end else begin
        res = c.neg ? -mag : mag;
      end
      return res;
    end
  endfunction

  assign en       = !out_vld || m_tready;
  assign s_tready = en;

  assign in_x = s_tdata[SAMPLE_W-1:0];
  assign in_y = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_z = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign px   = in_x * in_x;
  assign py   = in_y * in_y;
  assign pz   = in_z * in_z;

  // square stage, then sum stage feeding the root rows
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      sq_p[0].vld <= 1'b0;
      sq_r[0].vld <= 1'b0;
    end else if (en) begin
      v1          <= s_tvalid;
      sq_p[0].vld <= v1;
      sq_r[0].vld <= v1;
    end
    if (en) begin
      x1   <= in_x;
      y1   <= in_y;
      z1   <= in_z;
      sqx1 <= px[SQ_W-1:0];
      sqy1 <= py[SQ_W-1:0];
      sqz1 <= pz[SQ_W-1:0];
      upd1 <= (in_z != '0);

      sq_p[0].rad  <= SUM_W'(sqy1) + SUM_W'(sqz1);
      sq_p[0].rem  <= '0;
      sq_p[0].root <= '0;
      sq_p[0].num  <= x1;
      sq_r[0].rad  <= SUM_W'(sqx1) + SUM_W'(sqz1);
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
      sq_r[0].num  <= y1;
    end
  end

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    atp_sqrt_cell u_sqrt_p (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (sq_p[i]),
      .lane_out (sq_p[i+1])
    );
    atp_sqrt_cell u_sqrt_r (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .lane_in  (sq_r[i]),
      .lane_out (sq_r[i+1])
    );
  end

  assign cr_p_in = prep(sq_p[SQRT_STAGES]);
  assign cr_r_in = prep(sq_r[SQRT_STAGES]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_p[0].vld <= 1'b0;
      cr_r[0].vld <= 1'b0;
    end else if (en) begin
      cr_p[0].vld <= cr_p_in.vld;
      cr_r[0].vld <= cr_r_in.vld;
    end
    if (en) begin
      cr_p[0].cx    <= cr_p_in.cx;
      cr_p[0].cy    <= cr_p_in.cy;
      cr_p[0].ang   <= cr_p_in.ang;
      cr_p[0].neg   <= cr_p_in.neg;
      cr_p[0].nzero <= cr_p_in.nzero;
      cr_p[0].mzero <= cr_p_in.mzero;
      cr_r[0].cx    <= cr_r_in.cx;
      cr_r[0].cy    <= cr_r_in.cy;
      cr_r[0].ang   <= cr_r_in.ang;
      cr_r[0].neg   <= cr_r_in.neg;
      cr_r[0].nzero <= cr_r_in.nzero;
      cr_r[0].mzero <= cr_r_in.mzero;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    atp_cordic_cell u_cordic_p (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .idx      (IDX_W'(i)),
      .lane_in  (cr_p[i]),
      .lane_out (cr_p[i+1])
    );
    atp_cordic_cell u_cordic_r (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .idx      (IDX_W'(i)),
      .lane_in  (cr_r[i]),
      .lane_out (cr_r[i+1])
    );
  end

  atp_duty u_duty_x (.clk(clk), .en(en), .sample(x1), .duty(dx));
  atp_duty u_duty_y (.clk(clk), .en(en), .sample(y1), .duty(dy));
  atp_duty u_duty_z (.clk(clk), .en(en), .sample(z1), .duty(dz));

  // carry duties and the update flag alongside the angle rows
  always_ff @(posedge clk) begin
    if (en) begin
      upd_d[0]       <= upd1;
      upd_d[1]       <= upd_d[0];
      upd_d[2]       <= upd_d[1];
      side[0].duty_x <= dx;
      side[0].duty_y <= dy;
      side[0].duty_z <= dz;
      side[0].upd    <= upd_d[2];
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= cr_p[CORDIC_STAGES].vld & cr_r[CORDIC_STAGES].vld;
    end
    if (en) begin
      out_pitch <= finish_angle(cr_p[CORDIC_STAGES]);
      out_roll  <= finish_angle(cr_r[CORDIC_STAGES]);
      out_side  <= side[SIDE_DEPTH-1];
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(OUT_TDATA_W-2*ANGLE_W-3*DUTY_W){1'b0}},
                     out_side.duty_z, out_side.duty_y, out_side.duty_x,
                     out_roll, out_pitch};
  assign m_tuser  = out_side.upd;

endmodule

// ===== rtl/atp_checker.sv =====
// Port-level checks for the tilt unit, bound to the top level.
// Depends on atp_pkg and accel_tilt_pitch_roll_unit.
module atp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [atp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tuser
);
  import atp_pkg::*;

  logic signed [ANGLE_W-1:0] pitch_w;
  assign pitch_w = m_tdata[ANGLE_W-1:0];

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the output stage");

  a_duty_z: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[2*ANGLE_W+3*DUTY_W-1:2*ANGLE_W+2*DUTY_W] == '0)
    else $error("z duty nonzero while z is zero");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_w <= DEG90_Q7) && (pitch_w >= -DEG90_Q7))
    else $error("pitch beyond 90 degrees");

endmodule

bind accel_tilt_pitch_roll_unit atp_checker u_atp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking bench for accel_tilt_pitch_roll_unit: directed samples, then random ones.
// Checks each beat: typed rows, else its own fixed-point pitch, roll and LED duty model.
// Depends on atp_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb_top;
  import atp_pkg::*;

  localparam int DIR_N      = 21;
  localparam int RAND_N     = 1750;
  localparam int TAIL_WAIT  = 80;
  localparam int MAX_PRINTS = 30;

  typedef struct {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic [DUTY_W-1:0]         duty_x;
    logic [DUTY_W-1:0]         duty_y;
    logic [DUTY_W-1:0]         duty_z;
    logic                      upd;
  } tilt_result_t;

  // known = 1 means the expected beat is typed into the row
  typedef struct {
    int ax, ay, az;
    bit known;
    int pitch, roll, dx, dy, dz, upd;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // accel_x, accel_y, accel_z
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // pitch_deg, roll_deg, duty_x, duty_y, duty_z, zero fill
  logic                   m_tuser;   // leds_update

  tilt_result_t pending_tilt[$];
  dir_row_t     dir_tab [DIR_N];
  int           err_count;
  int           beats_checked;
  int           samples_sent;
  int           src_idle_pct;
  int           snk_idle_pct;

  accel_tilt_pitch_roll_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint atan_step_q16(input int i);
    longint v;
    case (i)
      0:  v = 2949120;
      1:  v = 1740967;
      2:  v = 919879;
      3:  v = 466945;
      4:  v = 234379;
      5:  v = 117304;
      6:  v = 58666;
      7:  v = 29335;
      8:  v = 14668;
      9:  v = 7334;
      10: v = 3667;
      11: v = 1833;
      12: v = 917;
      13: v = 458;
      14: v = 229;
      15: v = 115;
      16: v = 57;
      17: v = 29;
      18: v = 14;
      19: v = 7;
      20: v = 4;
      21: v = 2;
      22: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned acc;
    longint unsigned bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v   = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return acc;
  endfunction

  // atan2(num, sqrt(a^2 + b^2)) in Q7 degrees, odd in num
  function automatic logic signed [ANGLE_W-1:0] tilt_angle_q7(input longint num,
                                                              input longint a,
                                                              input longint b);
    longint unsigned ssum;
    longint mag, cx, cy, ang, xs, ys, res;
    ssum = longint'(a * a + b * b);
    mag  = longint'(floor_sqrt(ssum << 28));
    if (num == 0) return '0;
    if (mag == 0) return (num < 0) ? -DEG90_Q7 : DEG90_Q7;
    cx  = mag;
    cy  = ((num < 0) ? -num : num) <<< NUM_FRAC;
    ang = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + ys;
        cy  = cy - xs;
        ang = ang + atan_step_q16(i);
      end else begin
        cx  = cx - ys;
        cy  = cy + xs;
        ang = ang - atan_step_q16(i);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 5898240) ang = 5898240;
    res = (ang + 256) >>> ANG_SHIFT;
    if (num < 0) res = -res;
    return res[ANGLE_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] led_duty_q12(input longint v);
    longint mag, d;
    mag = (v < 0) ? -v : v;
    d   = (mag * 4096 + 510) / 1020;
    if (d > 4096) d = 4096;
    return d[DUTY_W-1:0];
  endfunction

  function automatic tilt_result_t predict_tilt(input int ax, input int ay, input int az);
    tilt_result_t r;
    r.pitch  = tilt_angle_q7(longint'(ax), longint'(ay), longint'(az));
    r.roll   = tilt_angle_q7(longint'(ay), longint'(ax), longint'(az));
    r.duty_x = led_duty_q12(longint'(ax));
    r.duty_y = led_duty_q12(longint'(ay));
    r.duty_z = led_duty_q12(longint'(az));
    r.upd    = (az != 0);
    return r;
  endfunction

  // full-scale words half the time, with zeros, extremes and values around the duty knee
  function automatic int rand_axis();
    logic signed [SAMPLE_W-1:0] w;
    case ($urandom_range(9))
      0:       w = '0;
      1: begin
        case ($urandom_range(3))
          0:       w = 16'sh8000;
          1:       w = 16'sh7fff;
          2:       w = 16'sh0001;
          default: w = 16'shffff;
        endcase
      end
      2, 3, 4: w = SAMPLE_W'(int'($urandom_range(2200)) - 1100);
      default: w = SAMPLE_W'($urandom);
    endcase
    return int'(w);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_sample(input int ax, input int ay, input int az,
                             input bit known, input tilt_result_t typed);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {16'(az), 16'(ay), 16'(ax)};
    do @(posedge clk); while (!s_tready);
    if (known)
      pending_tilt.push_back(typed);
    else
      pending_tilt.push_back(predict_tilt(ax, ay, az));
    samples_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    tilt_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_checked++;
      if (pending_tilt.size() == 0) begin
        report_mismatch("unexpected beat, pitch", int'($signed(m_tdata[14:0])), 0);
      end else begin
        want = pending_tilt.pop_front();
        if (m_tdata[14:0] !== want.pitch)
          report_mismatch("pitch_deg", int'($signed(m_tdata[14:0])), int'(want.pitch));
        if (m_tdata[29:15] !== want.roll)
          report_mismatch("roll_deg", int'($signed(m_tdata[29:15])), int'(want.roll));
        if (m_tdata[42:30] !== want.duty_x)
          report_mismatch("duty_x", int'(m_tdata[42:30]), int'(want.duty_x));
        if (m_tdata[55:43] !== want.duty_y)
          report_mismatch("duty_y", int'(m_tdata[55:43]), int'(want.duty_y));
        if (m_tdata[68:56] !== want.duty_z)
          report_mismatch("duty_z", int'(m_tdata[68:56]), int'(want.duty_z));
        if (m_tuser !== want.upd)
          report_mismatch("leds_update", int'(m_tuser), int'(want.upd));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tilt_result_t typed;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    err_count     = 0;
    beats_checked = 0;
    samples_sent  = 0;
    src_idle_pct  = 15;
    snk_idle_pct  = 54;

    //          x       y       z     known pitch   roll   dx    dy    dz   upd
    dir_tab = '{
      '{      0,      0,      0, 1,      0,      0,    0,    0,    0, 0},
      '{      0,      0,   1020, 1,      0,      0,    0,    0, 4096, 1},
      '{      0,      0, -32768, 1,      0,      0,    0,    0, 4096, 1},
      '{   1020,      0,      0, 1,  11520,      0, 4096,    0,    0, 0},
      '{ -32768,      0,      0, 1, -11520,      0, 4096,    0,    0, 0},
      '{      0,  32767,      0, 1,      0,  11520,    0, 4096,    0, 0},
      '{      0,     -1,      0, 1,      0, -11520,    0,    4,    0, 0},
      '{      0,      0,     -1, 1,      0,      0,    0,    0,    4, 1},
      '{  32767,  32767,  32767, 0,      0,      0,    0,    0,    0, 0},
      '{ -32768, -32768, -32768, 0,      0,      0,    0,    0,    0, 0},
      '{  32767, -32768,      0, 0,      0,      0,    0,    0,    0, 0},
      '{      1,      0,      1, 0,      0,      0,    0,    0,    0, 0},
      '{   1000,      0,   1000, 0,      0,      0,    0,    0,    0, 0},
      '{  -1019,   1021,     -1, 0,      0,      0,    0,    0,    0, 0},
      '{    510,   -510,      0, 0,      0,      0,    0,    0,    0, 0},
      '{  16384,      0, -16384, 0,      0,      0,    0,    0,    0, 0},
      '{     -1,     -1,     -1, 0,      0,      0,    0,    0,    0, 0},
      '{  21845, -21846,  21845, 0,      0,      0,    0,    0,    0, 0},
      '{ -21846,  21845, -21846, 0,      0,      0,    0,    0,    0, 0},
      '{      1,  32767, -32768, 0,      0,      0,    0,    0,    0, 0},
      '{  32767,      1,      0, 0,      0,      0,    0,    0,    0, 0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      typed.pitch  = ANGLE_W'(dir_tab[i].pitch);
      typed.roll   = ANGLE_W'(dir_tab[i].roll);
      typed.duty_x = DUTY_W'(dir_tab[i].dx);
      typed.duty_y = DUTY_W'(dir_tab[i].dy);
      typed.duty_z = DUTY_W'(dir_tab[i].dz);
      typed.upd    = dir_tab[i].upd[0];
      send_sample(dir_tab[i].ax, dir_tab[i].ay, dir_tab[i].az, dir_tab[i].known, typed);
    end

    // three idle profiles: sender light / receiver heavy, swapped, then none
    for (int n = 0; n < RAND_N; n++) begin
      if (n == RAND_N / 3) begin
        src_idle_pct = 54;
        snk_idle_pct = 15;
      end else if (n == 2 * RAND_N / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      send_sample(rand_axis(), rand_axis(), rand_axis(), 1'b0, typed);
    end
    s_tvalid <= 1'b0;

    while (pending_tilt.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d samples (%0d directed), compared %0d result beats, %0d mismatches",
             samples_sent, DIR_N, beats_checked, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
